// ===== rtl/core/mp2u_pkg.sv =====
// Package for the 2x2 max pooling / argmax unpooling block.
// Holds register indexes, register widths and reset values, and size limits.
// No dependencies.
`default_nettype none

package mp2u_pkg;

  localparam int MODE_BITS    = 1;
  localparam int WIDTH_BITS   = 8;
  localparam int HEIGHT_BITS  = 8;
  localparam int CHAN_BITS    = 5;
  localparam int CFG_DATA_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;

  localparam int HEIGHT_LIMIT  = 128;
  localparam int CHANNEL_LIMIT = 16;
  localparam int ROW_BITS      = 7;
  localparam int CHAN_IDX_BITS = 4;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_CODE_DEPTH = 16384;
  localparam int DEF_VALUE_BITS = 16;

  localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH    = 8'd64;
  localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT   = 8'd64;
  localparam logic [CHAN_BITS-1:0]   RESET_CHANNELS = 5'd1;

  // Cycles the map-size product needs after a register write.
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE     = 2'd0,
    REG_WIDTH    = 2'd1,
    REG_HEIGHT   = 2'd2,
    REG_CHANNELS = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    POS_TOP_LEFT     = 2'd0,
    POS_TOP_RIGHT    = 2'd1,
    POS_BOTTOM_LEFT  = 2'd2,
    POS_BOTTOM_RIGHT = 2'd3
  } pos_code_t;

endpackage

`default_nettype wire

// ===== rtl/core/max_pool_2x2_with_unpool.sv =====
// 2x2 stride-2 max pooling with argmax-routed gradient unpooling, Q8.8.
// Depends on mp2u_pkg (register indexes, widths, limits, reset values).
//
// Forward mode (backward_mode = 0) takes one sample word per clock in raster order when
// item_ready is high and returns one word (window maximum and winner position) per 2x2
// window through the stage-1 and output registers; top-row pairs live in a MAX_WIDTH/2
// entry memory and winner codes in a CODE_DEPTH entry memory, both read through a
// registered port. Backward mode takes one gradient word per pooled position and returns
// four words in position order, so each gradient takes four output words.
// After any register write the input is held off while the registered map-size product
// (channels x pooled width x pooled height) updates.
`default_nettype none

module max_pool_2x2_with_unpool #(
  parameter int MAX_WIDTH  = mp2u_pkg::DEF_MAX_WIDTH,
  parameter int CODE_DEPTH = mp2u_pkg::DEF_CODE_DEPTH,
  parameter int VALUE_BITS = mp2u_pkg::DEF_VALUE_BITS
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   write_enable,
  input  wire [mp2u_pkg::CFG_INDEX_BITS-1:0]    write_index,
  input  wire [mp2u_pkg::CFG_DATA_BITS-1:0]     write_data,
  input  wire                                   item_valid,
  output logic                                  item_ready,
  input  wire signed [VALUE_BITS-1:0]           sample,
  input  wire                                   map_start,
  output logic                                  result_valid,
  input  wire                                   result_ready,
  output logic signed [VALUE_BITS-1:0]          value,
  output logic [1:0]                            position,
  output logic                                  last
);

  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int PAW  = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int CNW  = PAW + 1;
  localparam int WW   = ($clog2(MAX_WIDTH + 1) > mp2u_pkg::WIDTH_BITS) ?
                        $clog2(MAX_WIDTH + 1) : mp2u_pkg::WIDTH_BITS;
  localparam int IDXW = $clog2(CODE_DEPTH);
  localparam int AW   = WW + mp2u_pkg::ROW_BITS;
  localparam int TW   = AW + mp2u_pkg::CHAN_BITS;
  localparam int PW   = IDXW + 1;
  localparam int CMPW = (PW > TW) ? PW : TW;
  localparam int HB   = mp2u_pkg::HEIGHT_BITS;
  localparam int CB   = mp2u_pkg::CHAN_BITS;
  localparam int RB   = mp2u_pkg::ROW_BITS;
  localparam int KB   = mp2u_pkg::CHAN_IDX_BITS;

  // configuration
  logic                 backward_mode;
  logic [mp2u_pkg::WIDTH_BITS-1:0] plane_width;
  logic [HB-1:0]        plane_height;
  logic [CB-1:0]        channel_count;
  logic [1:0]           settle;

  logic [WW-1:0]        eff_w;
  logic [WW-1:0]        w_even;
  logic [HB-1:0]        eff_h;
  logic [HB-1:0]        h_even;
  logic [CB-1:0]        eff_c;
  logic [AW-1:0]        area;
  logic [TW-1:0]        map_total;

  // position state
  logic [CNW-1:0]       column_count;
  logic [RB-1:0]        row_count;
  logic [KB-1:0]        channel_index;
  logic [IDXW-1:0]      pooled_index;
  logic signed [VALUE_BITS-1:0] left_sample;

  // memories
  logic [VALUE_BITS+1:0] top_mem [PAIR_DEPTH];
  logic [1:0]            code_mem [CODE_DEPTH];
  logic [VALUE_BITS+1:0] top_rd;
  logic [1:0]            code_rd;

  // stage 1
  logic                 p1_v;
  logic                 p1_bwd;
  logic signed [VALUE_BITS-1:0] p1_s;
  logic signed [VALUE_BITS-1:0] p1_left;
  logic [IDXW-1:0]      p1_idx;

  // output stage
  logic                 out_v;
  logic                 out_bwd;
  logic signed [VALUE_BITS-1:0] out_grad;
  logic [1:0]           out_code;
  logic [1:0]           beat;
  logic                 out_last;
  logic                 out_free;
  logic                 p1_go;
  logic                 accept;

  // stage A decode
  logic [CNW-1:0]       cur_col;
  logic [RB-1:0]        cur_row;
  logic [KB-1:0]        cur_ch;
  logic [IDXW-1:0]      cur_pool;
  logic [PAW-1:0]       pair;
  logic                 is_left;
  logic                 is_top;
  logic                 is_bot;
  logic                 emit;
  logic [WW-1:0]        col_ext;
  logic [HB-1:0]        row_ext;
  logic [CB-1:0]        ch_ext;
  logic                 wrap_col;
  logic                 wrap_row;
  logic                 wrap_ch;
  logic [CMPW-1:0]      pool_ext;
  logic [IDXW-1:0]      pool_adv;
  logic [CNW-1:0]       column_count_next;
  logic [RB-1:0]        row_count_next;
  logic [KB-1:0]        channel_index_next;
  logic [IDXW-1:0]      pooled_index_next;

  // stage 1 compare
  logic signed [VALUE_BITS-1:0] best_top;
  logic signed [VALUE_BITS-1:0] best_mid;
  logic signed [VALUE_BITS-1:0] best;
  logic [1:0]           code_top;
  logic [1:0]           code_mid;
  logic [1:0]           code;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      backward_mode <= 1'b0;
      plane_width   <= mp2u_pkg::RESET_WIDTH;
      plane_height  <= mp2u_pkg::RESET_HEIGHT;
      channel_count <= mp2u_pkg::RESET_CHANNELS;
      settle        <= mp2u_pkg::SETTLE_CYCLES;
    end else if (write_enable) begin
      settle <= mp2u_pkg::SETTLE_CYCLES;
      unique case (mp2u_pkg::cfg_index_t'(write_index))
        mp2u_pkg::REG_MODE:     backward_mode <= write_data[0];
        mp2u_pkg::REG_WIDTH:    plane_width   <= write_data[mp2u_pkg::WIDTH_BITS-1:0];
        mp2u_pkg::REG_HEIGHT:   plane_height  <= write_data[HB-1:0];
        mp2u_pkg::REG_CHANNELS: channel_count <= write_data[CB-1:0];
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  always_comb begin
    w_even = WW'({plane_width[mp2u_pkg::WIDTH_BITS-1:1], 1'b0});
    if (w_even < WW'(2))
      eff_w = WW'(2);
    else if (w_even > WW'(MAX_WIDTH))
      eff_w = WW'(MAX_WIDTH) & ~WW'(1);
    else
      eff_w = w_even;

    h_even = {plane_height[HB-1:1], 1'b0};
    if (h_even < HB'(2))
      eff_h = HB'(2);
    else if (h_even > HB'(mp2u_pkg::HEIGHT_LIMIT))
      eff_h = HB'(mp2u_pkg::HEIGHT_LIMIT);
    else
      eff_h = h_even;

    if (channel_count < CB'(1))
      eff_c = CB'(1);
    else if (channel_count > CB'(mp2u_pkg::CHANNEL_LIMIT))
      eff_c = CB'(mp2u_pkg::CHANNEL_LIMIT);
    else
      eff_c = channel_count;
  end

  // map size product, one multiply per register
  always_ff @(posedge clk) begin
    area      <= AW'(eff_w >> 1) * AW'(eff_h >> 1);
    map_total <= TW'(area) * TW'(eff_c);
  end

  // ---------------- handshake ----------------
  assign out_last   = !out_bwd || (beat == 2'd3);
  assign out_free   = !out_v || (result_ready && out_last);
  assign p1_go      = p1_v && out_free;
  assign item_ready = (settle == 2'd0) && (!p1_v || out_free);
  assign accept     = item_valid && item_ready;

  // ---------------- stage A ----------------
  always_comb begin
    cur_col  = map_start ? '0 : column_count;
    cur_row  = map_start ? '0 : row_count;
    cur_ch   = map_start ? '0 : channel_index;
    cur_pool = map_start ? '0 : pooled_index;
    pair     = cur_col[CNW-1:1];
    is_left  = !cur_col[0];
    is_top   = cur_col[0] && !cur_row[0];
    is_bot   = cur_col[0] && cur_row[0];
    emit     = backward_mode || is_bot;

    col_ext  = WW'(cur_col) + WW'(1);
    row_ext  = HB'(cur_row) + HB'(1);
    ch_ext   = CB'(cur_ch) + CB'(1);
    wrap_col = col_ext >= eff_w;
    wrap_row = wrap_col && (row_ext >= eff_h);
    wrap_ch  = wrap_row && (ch_ext >= eff_c);

    pool_ext = CMPW'(cur_pool) + CMPW'(1);
    if (pool_ext >= CMPW'(CODE_DEPTH) || pool_ext >= CMPW'(map_total))
      pool_adv = '0;
    else
      pool_adv = pool_ext[IDXW-1:0];

    if (backward_mode) begin
      column_count_next  = cur_col;
      row_count_next     = cur_row;
      channel_index_next = cur_ch;
      pooled_index_next  = pool_adv;
    end else begin
      column_count_next  = wrap_col ? '0 : col_ext[CNW-1:0];
      if (!wrap_col)
        row_count_next = cur_row;
      else
        row_count_next = wrap_row ? '0 : row_ext[RB-1:0];
      if (!wrap_row)
        channel_index_next = cur_ch;
      else
        channel_index_next = wrap_ch ? '0 : ch_ext[KB-1:0];
      if (wrap_ch)
        pooled_index_next = '0;
      else
        pooled_index_next = is_bot ? pool_adv : cur_pool;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      channel_index <= '0;
      pooled_index  <= '0;
      left_sample   <= '0;
    end else if (accept) begin
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      channel_index <= channel_index_next;
      pooled_index  <= pooled_index_next;
      if (!backward_mode && is_left)
        left_sample <= sample;
    end
  end

  // top-row pair store
  always_ff @(posedge clk) begin
    if (accept && !backward_mode && is_top) begin
      if (sample > left_sample)
        top_mem[pair] <= {sample, mp2u_pkg::POS_TOP_RIGHT};
      else
        top_mem[pair] <= {left_sample, mp2u_pkg::POS_TOP_LEFT};
    end
  end

  always_ff @(posedge clk) begin
    if (accept)
      top_rd <= top_mem[pair];
  end

  // winner code store
  always_ff @(posedge clk) begin
    if (p1_go && !p1_bwd)
      code_mem[p1_idx] <= code;
  end

  always_ff @(posedge clk) begin
    if (accept)
      code_rd <= code_mem[cur_pool];
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (accept && emit) begin
      p1_v <= 1'b1;
    end else if (p1_go) begin
      p1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      p1_bwd  <= backward_mode;
      p1_s    <= sample;
      p1_left <= left_sample;
      p1_idx  <= cur_pool;
    end
  end

  always_comb begin
    best_top = $signed(top_rd[VALUE_BITS+1:2]);
    code_top = top_rd[1:0];
    if (p1_left > best_top) begin
      best_mid = p1_left;
      code_mid = mp2u_pkg::POS_BOTTOM_LEFT;
    end else begin
      best_mid = best_top;
      code_mid = code_top;
    end
    if (p1_s > best_mid) begin
      best = p1_s;
      code = mp2u_pkg::POS_BOTTOM_RIGHT;
    end else begin
      best = best_mid;
      code = code_mid;
    end
  end

  // ---------------- output stage ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      beat  <= 2'd0;
    end else if (p1_go) begin
      out_v <= 1'b1;
      beat  <= 2'd0;
    end else if (out_v && result_ready) begin
      if (out_last)
        out_v <= 1'b0;
      else
        beat <= beat + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_go) begin
      out_bwd  <= p1_bwd;
      out_grad <= p1_bwd ? p1_s : best;
      out_code <= p1_bwd ? code_rd : code;
    end
  end

  assign result_valid = out_v;
  assign value        = (!out_bwd || beat == out_code) ? out_grad : '0;
  assign position     = out_bwd ? beat : out_code;
  assign last         = out_last;

  // ---------------- assertions ----------------
  a_beat_order: assert property (@(posedge clk) disable iff (rst)
    out_v && result_ready && out_bwd && beat != 2'd3 |=> out_v && beat == $past(beat) + 2'd1)
    else $error("backward word order broken");

  a_p1_hold: assert property (@(posedge clk) disable iff (rst)
    p1_v && !out_free |=> p1_v && $stable(p1_idx) && $stable(p1_s))
    else $error("stage 1 word lost while stalled");

  a_fwd_single: assert property (@(posedge clk) disable iff (rst)
    p1_go && !p1_bwd |=> out_v && last && !out_bwd)
    else $error("forward window gave other than one word");

  a_settle_block: assert property (@(posedge clk) disable iff (rst)
    write_enable |=> !item_ready ##1 !item_ready)
    else $error("input taken before map size settled");

endmodule

`default_nettype wire
